### rtl/core/tpnat_pkg.sv
// Shared types, constants and codes for the TCP port NAT flow table.
`default_nettype none

package tpnat_pkg;

  localparam int PORT_BITS = 16;
  localparam int TIME_BITS = 32;
  localparam int TABLE_DEPTH = 1 << PORT_BITS;
  localparam int WALK_BITS = PORT_BITS + 1;
  localparam int COUNT_BITS = PORT_BITS + 1;
  localparam int FLOWS_W = 17;
  localparam int CFG_W = 16;

  localparam logic [31:0] LOOPBACK_ADDR = 32'h7F00_0001;

  localparam logic [15:0] GC_INTERVAL_RST = 16'd60;
  localparam logic [15:0] IDLE_TIMEOUT_RST = 16'd300;

  typedef enum logic [1:0] {
    OP_OUTBOUND = 2'd0,
    OP_INBOUND  = 2'd1,
    OP_LOOKUP   = 2'd2,
    OP_TICK     = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    CFG_RELAY_PORT   = 2'd0,
    CFG_GC_INTERVAL  = 2'd1,
    CFG_IDLE_TIMEOUT = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_EXEC,
    ST_SWEEP,
    ST_SWEEP_DONE
  } state_t;

  typedef struct packed {
    logic                 valid;
    logic [TIME_BITS-1:0] last_seen;
  } meta_t;

  typedef struct packed {
    logic [31:0] orig_src_ip;
    logic [31:0] orig_dst_ip;
    logic [15:0] orig_dst_port;
    logic [31:0] owner_pid;
    logic [31:0] owner_ifx;
  } flow_data_t;

  localparam int META_W = $bits(meta_t);
  localparam int DATA_W = $bits(flow_data_t);

endpackage

`default_nettype wire

### rtl/core/tpnat_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
`default_nettype none

module tpnat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

`default_nettype wire

### rtl/core/tcp_port_nat_flow_table.sv
// Top level of the TCP port NAT flow table with idle aging.
//
//   channel | ports                          | beat moves
//   --------+--------------------------------+------------------------------
//   in      | in_valid / in_stall  + fields  | one operation (packet, query, tick)
//   out     | out_valid / out_stall + fields | one result per operation
//   cfg     | cfg_wr_en, cfg_index, cfg_data | one register write
//
// A packet or query does a table read, then the modify/write-back together with
// loading the output register. A tick takes the same path, or runs an aging
// sweep that walks the entry metadata memory one entry per cycle. After reset
// a clearing pass writes every entry invalid, with in_stall high. A stalled
// result holds the next operation in its write-back step; no further item is
// taken meanwhile.
`default_nettype none

module tcp_port_nat_flow_table
  import tpnat_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,

  input  wire logic                  cfg_wr_en,
  input  wire logic [1:0]            cfg_index,
  input  wire logic [CFG_W-1:0]      cfg_data,

  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic [1:0]            in_operation,
  input  wire logic [31:0]           in_src_ip,
  input  wire logic [31:0]           in_dst_ip,
  input  wire logic [15:0]           in_src_port,
  input  wire logic [15:0]           in_dst_port,
  input  wire logic [31:0]           in_process_id,
  input  wire logic [31:0]           in_interface_index,
  input  wire logic [15:0]           in_lookup_port,

  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic                       out_handled,
  output logic [31:0]                out_src_ip_out,
  output logic [31:0]                out_dst_ip_out,
  output logic [15:0]                out_src_port_out,
  output logic [15:0]                out_dst_port_out,
  output logic [31:0]                out_pid_out,
  output logic [31:0]                out_interface_out,
  output logic [FLOWS_W-1:0]         out_tracked_flows
);

  // configuration
  logic [15:0] relay_port_r;
  logic [15:0] gc_interval_r;
  logic [15:0] idle_timeout_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      relay_port_r   <= '0;
      gc_interval_r  <= GC_INTERVAL_RST;
      idle_timeout_r <= IDLE_TIMEOUT_RST;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_RELAY_PORT:   relay_port_r   <= cfg_data;
        CFG_GC_INTERVAL:  gc_interval_r  <= cfg_data;
        CFG_IDLE_TIMEOUT: idle_timeout_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // control state
  state_t                 state_r, state_nxt;
  logic [WALK_BITS-1:0]   walk_r, walk_nxt;
  logic                   sw_pend_r, sw_pend_nxt;
  logic [PORT_BITS-1:0]   sw_idx_r, sw_idx_nxt;
  logic [TIME_BITS-1:0]   now_r, now_nxt;
  logic [TIME_BITS-1:0]   last_sweep_r, last_sweep_nxt;
  logic [COUNT_BITS-1:0]  count_r, count_nxt;

  // latched item
  op_t         op_r;
  logic [31:0] src_ip_r, dst_ip_r, pid_r, ifx_r;
  logic [15:0] src_port_r, dst_port_r, lookup_port_r;

  // output register
  logic        out_valid_r, out_valid_nxt;
  logic        out_load;
  logic        res_handled;
  logic [31:0] res_src_ip, res_dst_ip, res_pid, res_ifx;
  logic [15:0] res_src_port, res_dst_port;
  logic        handled_r;
  logic [31:0] src_ip_out_r, dst_ip_out_r, pid_out_r, ifx_out_r;
  logic [15:0] src_port_out_r, dst_port_out_r;
  logic [COUNT_BITS-1:0] flows_out_r;

  // memories
  logic                 meta_we, meta_re, data_we, data_re;
  logic [PORT_BITS-1:0] meta_waddr, meta_raddr, data_waddr, data_raddr;
  meta_t                meta_wdata, meta_rd;
  flow_data_t           data_wdata, data_rd;
  logic [META_W-1:0]    meta_rd_bits;
  logic [DATA_W-1:0]    data_rd_bits;

  tpnat_ram #(.WIDTH(META_W), .DEPTH(TABLE_DEPTH)) u_meta_ram (
    .clk     (clk),
    .wr_en   (meta_we),
    .wr_addr (meta_waddr),
    .wr_data (meta_wdata),
    .rd_en   (meta_re),
    .rd_addr (meta_raddr),
    .rd_data (meta_rd_bits)
  );

  tpnat_ram #(.WIDTH(DATA_W), .DEPTH(TABLE_DEPTH)) u_data_ram (
    .clk     (clk),
    .wr_en   (data_we),
    .wr_addr (data_waddr),
    .wr_data (data_wdata),
    .rd_en   (data_re),
    .rd_addr (data_raddr),
    .rd_data (data_rd_bits)
  );

  assign meta_rd = meta_t'(meta_rd_bits);
  assign data_rd = flow_data_t'(data_rd_bits);

  logic                 accept, out_free;
  logic [PORT_BITS-1:0] in_idx, item_idx;
  logic [TIME_BITS-1:0] now_inc, gc_elapsed, idle_elapsed;
  logic                 sweep_go, is_loop_pkt, inbound_hit, expired;

  assign in_stall = (state_r != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  always_comb begin
    unique case (op_t'(in_operation))
      OP_OUTBOUND: in_idx = in_src_port[PORT_BITS-1:0];
      OP_INBOUND:  in_idx = in_dst_port[PORT_BITS-1:0];
      default:     in_idx = in_lookup_port[PORT_BITS-1:0];
    endcase
    unique case (op_r)
      OP_OUTBOUND: item_idx = src_port_r[PORT_BITS-1:0];
      OP_INBOUND:  item_idx = dst_port_r[PORT_BITS-1:0];
      default:     item_idx = lookup_port_r[PORT_BITS-1:0];
    endcase
  end

  assign now_inc      = now_r + TIME_BITS'(1);
  assign gc_elapsed   = now_inc - last_sweep_r;
  assign sweep_go     = gc_elapsed >= TIME_BITS'(gc_interval_r);
  assign idle_elapsed = now_r - meta_rd.last_seen;
  assign expired      = meta_rd.valid && (idle_elapsed > TIME_BITS'(idle_timeout_r));
  assign is_loop_pkt  = (src_ip_r == LOOPBACK_ADDR) || (dst_ip_r == LOOPBACK_ADDR);
  assign inbound_hit  = (src_port_r == relay_port_r) && (src_ip_r == LOOPBACK_ADDR) &&
                        meta_rd.valid;

  always_comb begin
    state_nxt      = state_r;
    walk_nxt       = walk_r;
    sw_pend_nxt    = sw_pend_r;
    sw_idx_nxt     = sw_idx_r;
    now_nxt        = now_r;
    last_sweep_nxt = last_sweep_r;
    count_nxt      = count_r;

    meta_we    = 1'b0;
    meta_waddr = item_idx;
    meta_wdata = '{valid: 1'b1, last_seen: now_r};
    meta_re    = 1'b0;
    meta_raddr = in_idx;
    data_we    = 1'b0;
    data_waddr = item_idx;
    data_wdata = '{orig_src_ip: src_ip_r, orig_dst_ip: dst_ip_r,
                   orig_dst_port: dst_port_r, owner_pid: pid_r, owner_ifx: ifx_r};
    data_re    = 1'b0;
    data_raddr = in_idx;

    out_load     = 1'b0;
    res_handled  = 1'b0;
    res_src_ip   = '0;
    res_dst_ip   = '0;
    res_src_port = '0;
    res_dst_port = '0;
    res_pid      = '0;
    res_ifx      = '0;

    unique case (state_r)
      ST_CLEAR: begin
        meta_we    = 1'b1;
        meta_waddr = walk_r[PORT_BITS-1:0];
        meta_wdata = '{valid: 1'b0, last_seen: '0};
        walk_nxt   = walk_r + WALK_BITS'(1);
        if (walk_r == WALK_BITS'(TABLE_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (accept) begin
          meta_re   = 1'b1;
          data_re   = 1'b1;
          state_nxt = ST_EXEC;
        end
      end

      ST_EXEC: begin
        if (op_r == OP_TICK && sweep_go) begin
          now_nxt        = now_inc;
          last_sweep_nxt = now_inc;
          walk_nxt       = '0;
          sw_pend_nxt    = 1'b0;
          state_nxt      = ST_SWEEP;
        end else if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
          unique case (op_r)
            OP_OUTBOUND: begin
              if (is_loop_pkt) begin
                res_src_ip   = src_ip_r;
                res_dst_ip   = dst_ip_r;
                res_src_port = src_port_r;
                res_dst_port = dst_port_r;
              end else begin
                meta_we      = 1'b1;
                data_we      = 1'b1;
                if (!meta_rd.valid) begin
                  count_nxt = count_r + COUNT_BITS'(1);
                end
                res_handled  = 1'b1;
                res_src_ip   = LOOPBACK_ADDR;
                res_dst_ip   = LOOPBACK_ADDR;
                res_src_port = src_port_r;
                res_dst_port = relay_port_r;
              end
            end
            OP_INBOUND: begin
              if (inbound_hit) begin
                meta_we      = 1'b1;
                res_handled  = 1'b1;
                res_src_ip   = data_rd.orig_dst_ip;
                res_dst_ip   = data_rd.orig_src_ip;
                res_src_port = data_rd.orig_dst_port;
                res_dst_port = dst_port_r;
                res_ifx      = data_rd.owner_ifx;
              end else begin
                res_src_ip   = src_ip_r;
                res_dst_ip   = dst_ip_r;
                res_src_port = src_port_r;
                res_dst_port = dst_port_r;
              end
            end
            OP_LOOKUP: begin
              if (meta_rd.valid) begin
                res_handled  = 1'b1;
                res_src_ip   = data_rd.orig_src_ip;
                res_dst_ip   = data_rd.orig_dst_ip;
                res_src_port = lookup_port_r;
                res_dst_port = data_rd.orig_dst_port;
                res_pid      = data_rd.owner_pid;
              end
            end
            OP_TICK: begin
              now_nxt = now_inc;
            end
          endcase
        end
      end

      ST_SWEEP: begin
        if (!walk_r[PORT_BITS]) begin
          meta_re     = 1'b1;
          meta_raddr  = walk_r[PORT_BITS-1:0];
          walk_nxt    = walk_r + WALK_BITS'(1);
          sw_pend_nxt = 1'b1;
          sw_idx_nxt  = walk_r[PORT_BITS-1:0];
        end else begin
          sw_pend_nxt = 1'b0;
        end
        if (sw_pend_r && expired) begin
          meta_we    = 1'b1;
          meta_waddr = sw_idx_r;
          meta_wdata = '{valid: 1'b0, last_seen: meta_rd.last_seen};
          if (count_r != '0) begin
            count_nxt = count_r - COUNT_BITS'(1);
          end
        end
        if (walk_r[PORT_BITS] && !sw_pend_r) begin
          state_nxt = ST_SWEEP_DONE;
        end
      end

      ST_SWEEP_DONE: begin
        if (out_free) begin
          out_load    = 1'b1;
          res_handled = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase

    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      walk_r       <= '0;
      sw_pend_r    <= 1'b0;
      now_r        <= '0;
      last_sweep_r <= '0;
      count_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      walk_r       <= walk_nxt;
      sw_pend_r    <= sw_pend_nxt;
      now_r        <= now_nxt;
      last_sweep_r <= last_sweep_nxt;
      count_r      <= count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sw_idx_r <= sw_idx_nxt;
    if (accept) begin
      op_r          <= op_t'(in_operation);
      src_ip_r      <= in_src_ip;
      dst_ip_r      <= in_dst_ip;
      src_port_r    <= in_src_port;
      dst_port_r    <= in_dst_port;
      pid_r         <= in_process_id;
      ifx_r         <= in_interface_index;
      lookup_port_r <= in_lookup_port;
    end
    if (out_load) begin
      handled_r      <= res_handled;
      src_ip_out_r   <= res_src_ip;
      dst_ip_out_r   <= res_dst_ip;
      src_port_out_r <= res_src_port;
      dst_port_out_r <= res_dst_port;
      pid_out_r      <= res_pid;
      ifx_out_r      <= res_ifx;
      flows_out_r    <= count_nxt;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_handled       = handled_r;
  assign out_src_ip_out    = src_ip_out_r;
  assign out_dst_ip_out    = dst_ip_out_r;
  assign out_src_port_out  = src_port_out_r;
  assign out_dst_port_out  = dst_port_out_r;
  assign out_pid_out       = pid_out_r;
  assign out_interface_out = ifx_out_r;
  assign out_tracked_flows = FLOWS_W'(flows_out_r);

endmodule

`default_nettype wire
